// ===== hdl/swal_pkg.sv =====
// Shared types, constants and helpers for the sliding window action limiter.
package swal_pkg;

  // Default sizing of the limiter.
  localparam int unsigned NUM_ACTIONS_DEF   = 8;
  localparam int unsigned HISTORY_DEPTH_DEF = 128;
  localparam int unsigned TIME_BITS_DEF     = 48;

  // Register reset values.
  localparam logic [31:0] WINDOW_MS_RST      = 32'd60000;
  localparam logic [7:0]  SPIN_LIMIT_RST     = 8'd100;
  localparam logic [7:0]  PAYMENT_LIMIT_RST  = 8'd10;
  localparam logic [7:0]  DEFAULT_LIMIT_RST  = 8'd50;
  localparam logic [2:0]  SPIN_ACTION_RST    = 3'd0;
  localparam logic [2:0]  PAYMENT_ACTION_RST = 3'd1;
  localparam logic [30:0] MAX_AMOUNT_RST     = 31'd1000000;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_WINDOW_MS      = 3'd0;
  localparam logic [2:0] REG_SPIN_LIMIT     = 3'd1;
  localparam logic [2:0] REG_PAYMENT_LIMIT  = 3'd2;
  localparam logic [2:0] REG_DEFAULT_LIMIT  = 3'd3;
  localparam logic [2:0] REG_SPIN_ACTION    = 3'd4;
  localparam logic [2:0] REG_PAYMENT_ACTION = 3'd5;
  localparam logic [2:0] REG_MAX_AMOUNT     = 3'd6;

  // Request kinds and verdict codes.
  localparam logic       KIND_GAME        = 1'b0;
  localparam logic       KIND_PAYMENT     = 1'b1;
  localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
  localparam logic [1:0] VERDICT_LIMITED  = 2'd1;
  localparam logic [1:0] VERDICT_INVALID  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [2:0]         action_id;
    logic signed [31:0] amount_cents;
    logic [47:0]        now_ms;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] verdict;
    logic [7:0] window_count;
  } res_t;

  typedef struct packed {
    logic [31:0] window_ms;
    logic [7:0]  spin_limit;
    logic [7:0]  payment_limit;
    logic [7:0]  default_limit;
    logic [2:0]  spin_action;
    logic [2:0]  payment_action;
    logic [30:0] max_amount_cents;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture the request
    logic fetch;         // copy ring pointers, read the head stamp
    logic reply_invalid; // report a rejected payment
    logic rd_issue;      // read the stamp at the working head
    logic pop;           // drop the head entry
    logic decide;        // limit check, append, write back, report
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic invalid;    // captured payment has a bad amount
    logic fetch_zero; // ring of the captured action is empty
    logic cur_zero;   // working count is zero
    logic expired;    // stamp just read is older than the window
  } sts_t;

  // Folds a 3-bit id into the range of n actions (for n >= 2) by repeated subtraction.
  function automatic logic [2:0] fold_act(logic [2:0] v, int unsigned n);
    logic [2:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (32'(r) >= n) begin
        r = 3'(32'(r) - n);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/swal_cfg.sv =====
// Configuration register file of the sliding window action limiter.
module swal_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output swal_pkg::cfg_t     cfg
);

  swal_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms        <= swal_pkg::WINDOW_MS_RST;
      cfg_r.spin_limit       <= swal_pkg::SPIN_LIMIT_RST;
      cfg_r.payment_limit    <= swal_pkg::PAYMENT_LIMIT_RST;
      cfg_r.default_limit    <= swal_pkg::DEFAULT_LIMIT_RST;
      cfg_r.spin_action      <= swal_pkg::SPIN_ACTION_RST;
      cfg_r.payment_action   <= swal_pkg::PAYMENT_ACTION_RST;
      cfg_r.max_amount_cents <= swal_pkg::MAX_AMOUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swal_pkg::REG_WINDOW_MS:      cfg_r.window_ms        <= cfg_wdata;
        swal_pkg::REG_SPIN_LIMIT:     cfg_r.spin_limit       <= cfg_wdata[7:0];
        swal_pkg::REG_PAYMENT_LIMIT:  cfg_r.payment_limit    <= cfg_wdata[7:0];
        swal_pkg::REG_DEFAULT_LIMIT:  cfg_r.default_limit    <= cfg_wdata[7:0];
        swal_pkg::REG_SPIN_ACTION:    cfg_r.spin_action      <= cfg_wdata[2:0];
        swal_pkg::REG_PAYMENT_ACTION: cfg_r.payment_action   <= cfg_wdata[2:0];
        swal_pkg::REG_MAX_AMOUNT:     cfg_r.max_amount_cents <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/swal_ctrl.sv =====
// Controller state machine of the sliding window action limiter.
module swal_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  swal_pkg::sts_t sts,
  output swal_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_READ,
    S_CHECK,
    S_DECIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  assign busy = busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.invalid) begin
          cmd.reply_invalid = 1'b1;
          state_nxt         = S_IDLE;
        end else if (sts.fetch_zero) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_READ: begin
        if (sts.cur_zero) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.expired) begin
          cmd.pop   = 1'b1;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

// ===== hdl/swal_dp.sv =====
// Datapath of the sliding window action limiter: ring pointers, stamp memory, result.
module swal_dp #(
  parameter int unsigned NUM_ACTIONS   = swal_pkg::NUM_ACTIONS_DEF,
  parameter int unsigned HISTORY_DEPTH = swal_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned TIME_BITS     = swal_pkg::TIME_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  swal_pkg::req_t in_req,
  input  swal_pkg::cfg_t cfg,
  input  swal_pkg::cmd_t cmd,
  output swal_pkg::sts_t sts,
  output logic           out_valid,
  output swal_pkg::res_t out_res
);

  localparam int unsigned AW    = $clog2(NUM_ACTIONS);
  localparam int unsigned HW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned DEPTH = NUM_ACTIONS * HISTORY_DEPTH;
  localparam int unsigned MW    = $clog2(DEPTH);

  // Per-action ring pointers, cleared by reset.
  logic [HW-1:0] head_r [NUM_ACTIONS];
  logic [CW-1:0] cnt_r  [NUM_ACTIONS];

  // Stamp store: one ring of HISTORY_DEPTH entries per action.
  logic [TIME_BITS-1:0] mem [DEPTH];
  logic [TIME_BITS-1:0] rd_data_r;

  // Captured request and working copies of the ring pointers.
  logic [TIME_BITS-1:0] now_r;
  logic [AW-1:0]        act_r;
  logic                 invalid_r;
  logic [HW-1:0]        cur_head_r;
  logic [CW-1:0]        cur_cnt_r;
  logic [CW-1:0]        limit_r;

  logic                 out_valid_r;
  swal_pkg::res_t       out_res_r;

  logic [AW-1:0]        in_act;
  logic [AW-1:0]        pay_act;
  logic [AW-1:0]        spin_act;
  logic                 amount_bad;
  logic [7:0]           lim_raw;
  logic [CW-1:0]        lim_sat;
  logic [TIME_BITS-1:0] age;
  logic [HW:0]          tail_sum;
  logic [HW-1:0]        tail_pos;
  logic [MW-1:0]        rd_addr;
  logic [MW-1:0]        wr_addr;
  logic [MW-1:0]        act_base;
  logic [CW-1:0]        cnt_inc;

  assign pay_act  = AW'(swal_pkg::fold_act(cfg.payment_action, NUM_ACTIONS));
  assign spin_act = AW'(swal_pkg::fold_act(cfg.spin_action, NUM_ACTIONS));
  assign in_act   = (in_req.kind == swal_pkg::KIND_PAYMENT) ? pay_act :
                    AW'(swal_pkg::fold_act(in_req.action_id, NUM_ACTIONS));

  // A negative amount, or one above the maximum, makes a payment invalid.
  assign amount_bad = in_req.amount_cents[31] ||
                      (in_req.amount_cents[30:0] > cfg.max_amount_cents);

  // Spin limit wins when the spin and payment ids coincide.
  always_comb begin
    priority if (act_r == spin_act) begin
      lim_raw = cfg.spin_limit;
    end else if (act_r == pay_act) begin
      lim_raw = cfg.payment_limit;
    end else begin
      lim_raw = cfg.default_limit;
    end
  end

  assign lim_sat = (32'(lim_raw) > HISTORY_DEPTH) ? CW'(HISTORY_DEPTH) : CW'(lim_raw);

  // Age wraps modulo the time width.
  assign age = now_r - rd_data_r;

  assign act_base = MW'(act_r) * MW'(HISTORY_DEPTH);
  assign rd_addr  = act_base + MW'(cmd.fetch ? head_r[act_r] : cur_head_r);

  // Append slot; the count is below the depth whenever an append happens.
  assign tail_sum = {1'b0, cur_head_r} + (HW + 1)'(cur_cnt_r);
  assign tail_pos = (32'(tail_sum) >= HISTORY_DEPTH) ?
                    HW'(32'(tail_sum) - HISTORY_DEPTH) : HW'(tail_sum);
  assign wr_addr  = act_base + MW'(tail_pos);
  assign cnt_inc  = cur_cnt_r + 1'b1;

  assign sts.invalid    = invalid_r;
  assign sts.fetch_zero = (cnt_r[act_r] == '0);
  assign sts.cur_zero   = (cur_cnt_r == '0);
  assign sts.expired    = (age > TIME_BITS'(cfg.window_ms));

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Captured request and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= TIME_BITS'(in_req.now_ms);
      act_r     <= in_act;
      invalid_r <= (in_req.kind == swal_pkg::KIND_PAYMENT) && amount_bad;
    end
    if (cmd.fetch) begin
      cur_head_r <= head_r[act_r];
      cur_cnt_r  <= cnt_r[act_r];
      limit_r    <= lim_sat;
    end
    if (cmd.pop) begin
      cur_head_r <= (cur_head_r == HW'(HISTORY_DEPTH - 1)) ? '0 : cur_head_r + 1'b1;
      cur_cnt_r  <= cur_cnt_r - 1'b1;
    end
  end

  // Stamp memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.fetch || cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.decide && (cur_cnt_r < limit_r)) begin
      mem[wr_addr] <= now_r;
    end
  end

  // Ring pointers and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.reply_invalid || cmd.decide;
      if (cmd.decide) begin
        head_r[act_r] <= cur_head_r;
        cnt_r[act_r]  <= (cur_cnt_r < limit_r) ? cnt_inc : cur_cnt_r;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.reply_invalid) begin
      out_res_r.accepted     <= 1'b0;
      out_res_r.verdict      <= swal_pkg::VERDICT_INVALID;
      out_res_r.window_count <= 8'(cnt_r[act_r]);
    end else if (cmd.decide) begin
      if (cur_cnt_r < limit_r) begin
        out_res_r.accepted     <= 1'b1;
        out_res_r.verdict      <= swal_pkg::VERDICT_ACCEPTED;
        out_res_r.window_count <= 8'(cnt_inc);
      end else begin
        out_res_r.accepted     <= 1'b0;
        out_res_r.verdict      <= swal_pkg::VERDICT_LIMITED;
        out_res_r.window_count <= 8'(cur_cnt_r);
      end
    end
  end

endmodule

// ===== hdl/sliding_window_action_limiter_unit.sv =====
// Top level of the sliding window action limiter: config registers, controller, datapath.
// A request is captured, then the action's ring pointers and head stamp are fetched. An empty
// ring goes straight to the decision; otherwise the head stamp is compared with the window, and
// each expired entry popped costs one more memory read and compare before the decision.
// A payment with a bad amount is reported straight after the fetch. The unit takes no new
// request until the current one has been decided or rejected.
// Synchronous active-low reset empties every ring and restores register defaults at once;
// stamps need no clearing. Results cannot be stalled.
module sliding_window_action_limiter_unit #(
  parameter int unsigned NUM_ACTIONS   = swal_pkg::NUM_ACTIONS_DEF,
  parameter int unsigned HISTORY_DEPTH = swal_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned TIME_BITS     = swal_pkg::TIME_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  // Request channel: taken when start is high and busy is low.
  input  logic           start,
  output logic           busy,
  input  swal_pkg::req_t in_req,
  // Result channel: one-cycle strobe, no back-pressure.
  output logic           out_valid,
  output swal_pkg::res_t out_res,
  // Configuration write channel.
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);

  swal_pkg::cfg_t cfg;
  swal_pkg::cmd_t cmd;
  swal_pkg::sts_t sts;

  // Register file. Writes are expected only while no request is in flight, so the
  // datapath reads the registers directly without a shadow copy.
  swal_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The controller sequences each request: capture, fetch the ring pointers and head stamp,
  // pop expired entries one at a time, then decide and report (bad payments report at fetch).
  swal_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the per-action rings and the stamp memory. Pops work on a
  // working copy of head and count, which is written back at the decision.
  swal_dp #(
    .NUM_ACTIONS   (NUM_ACTIONS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
